// File: design/mscd_pkg.sv
// ---------------------------------------------------------------------------
// mscd_pkg
// Shared types and constants for the minimum square-count engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mscd_pkg;

   localparam int unsigned MAX_VALUE_ENTRIES = 16384;
   localparam int unsigned QUERY_W           = 14;
   localparam int unsigned COUNT_W           = 3;
   localparam int unsigned SMALL_LIMIT       = 3;

   localparam logic [COUNT_W-1:0] COUNT_INIT = 3'd7;

   typedef struct packed {
      logic load;        // take a new query
      logic set_small;   // answer is the query itself
      logic init_wr;     // write seed entry i = i
      logic scan_rd;     // read entry i - j*j, step j
      logic entry_wr;    // write best into entry i
      logic next_entry;  // advance to entry i + 1
      logic out_load;    // move result into the output register
   } mscd_cmd_type;

   typedef struct packed {
      logic n_le_seed;   // query at or below the seed range
      logic sq_le_i;     // current square still fits entry i
      logic i_is_n;      // entry i is the queried one
      logic init_last;   // last seed entry
      logic out_free;    // output register can take a result
   } mscd_status_type;

endpackage

`default_nettype wire

// File: design/min_squares_count_dp.sv
// ---------------------------------------------------------------------------
// min_squares_count_dp
// Least number of perfect squares summing to a query, by a table rebuilt
// bottom up for every query larger than 3.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_query_value[13:0]
//  rsp      out  rsp_valid/rsp_stall   rsp_square_count[2:0]
//
//  Queries of 3 or less skip the table: CHECK takes the query as the result
//  and DONE moves it into the output register. Larger n: entries 0..3 are
//  seeded, then each entry i=4..n is scanned one square per cycle through
//  the single table read port and written with its minimum.
//  One query at a time; a finished beat waits in the output register while
//  the next query is accepted. Reset clears control only, no table sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_squares_count_dp #(
   parameter int unsigned MaxValueEntries = mscd_pkg::MAX_VALUE_ENTRIES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mscd_pkg::QUERY_W-1:0]  req_query_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [mscd_pkg::COUNT_W-1:0]  rsp_square_count
);

   mscd_pkg::mscd_cmd_type    cmd;
   mscd_pkg::mscd_status_type status;

   mscd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mscd_dp #(
      .MaxValueEntries (MaxValueEntries)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_query_value  (req_query_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_square_count (rsp_square_count),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// File: design/mscd_ram.sv
// ---------------------------------------------------------------------------
// mscd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/mscd_ctrl.sv
// ---------------------------------------------------------------------------
// mscd_ctrl
// Sequencer: seeds the table, scans squares per entry, writes, responds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mscd_pkg::mscd_status_type status,
   output mscd_pkg::mscd_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_INIT  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.n_le_seed) begin
               cmd.set_small = 1'b1;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.init_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.sq_le_i) begin
               cmd.scan_rd = 1'b1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.entry_wr = 1'b1;
            if (status.i_is_n) begin
               state_in = ST_DONE;
            end else begin
               cmd.next_entry = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: design/mscd_dp.sv
// ---------------------------------------------------------------------------
// mscd_dp
// Datapath: entry/square counters, count table, running minimum, output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscd_dp #(
   parameter int unsigned MaxValueEntries = mscd_pkg::MAX_VALUE_ENTRIES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [mscd_pkg::QUERY_W-1:0]        req_query_value,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic      [mscd_pkg::COUNT_W-1:0]        rsp_square_count,
   input  wire mscd_pkg::mscd_cmd_type              cmd,
   output mscd_pkg::mscd_status_type                status
);

   localparam int unsigned AddrW = $clog2(MaxValueEntries);
   localparam int unsigned SqW   = AddrW + 2;
   localparam int unsigned CW    = mscd_pkg::COUNT_W;

   logic [AddrW-1:0] n_ff,    n_in;
   logic [AddrW-1:0] i_ff,    i_in;
   logic [SqW-1:0]   j_ff,    j_in;
   logic [SqW-1:0]   sq_ff,   sq_in;
   logic [CW-1:0]    best_ff, best_in;
   logic [CW-1:0]    res_ff,  res_in;
   logic             pend_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;

   logic             ram_we;
   logic [AddrW-1:0] ram_waddr;
   logic [CW-1:0]    ram_wdata;
   logic [AddrW-1:0] ram_raddr;
   logic [CW-1:0]    ram_rdata;
   logic [CW:0]      cand;

   mscd_ram #(
      .Width (CW),
      .Depth (MaxValueEntries)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.scan_rd),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_we    = cmd.init_wr | cmd.entry_wr;
   assign ram_waddr = i_ff;
   assign ram_wdata = cmd.init_wr ? CW'(i_ff) : best_ff;
   assign ram_raddr = AddrW'(SqW'(i_ff) - sq_ff);
   assign cand      = {1'b0, ram_rdata} + (CW+1)'(1);

   always_comb begin
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sq_in        = sq_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_count_in = rsp_count_ff;

      if (pend_ff && (cand < {1'b0, best_ff})) begin
         best_in = CW'(cand);
      end

      if (cmd.load) begin
         if (32'(req_query_value) >= 32'(MaxValueEntries)) begin
            n_in = AddrW'(MaxValueEntries - 1);
         end else begin
            n_in = AddrW'(req_query_value);
         end
         i_in    = '0;
         j_in    = SqW'(1);
         sq_in   = SqW'(1);
         best_in = mscd_pkg::COUNT_INIT;
      end
      if (cmd.set_small) begin
         res_in = CW'(n_ff);
      end
      if (cmd.init_wr) begin
         i_in = i_ff + AddrW'(1);
      end
      if (cmd.scan_rd) begin
         sq_in = sq_ff + SqW'({j_ff, 1'b1});
         j_in  = j_ff + SqW'(1);
      end
      if (cmd.entry_wr) begin
         res_in = best_ff;
      end
      if (cmd.next_entry) begin
         i_in    = i_ff + AddrW'(1);
         j_in    = SqW'(1);
         sq_in   = SqW'(1);
         best_in = mscd_pkg::COUNT_INIT;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      sq_ff        <= sq_in;
      best_ff      <= best_in;
      res_ff       <= res_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= cmd.scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.n_le_seed = (n_ff <= AddrW'(mscd_pkg::SMALL_LIMIT));
   assign status.sq_le_i   = (sq_ff <= SqW'(i_ff));
   assign status.i_is_n    = (i_ff == n_ff);
   assign status.init_last = (i_ff == AddrW'(mscd_pkg::SMALL_LIMIT));
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_count = rsp_count_ff;

endmodule

`default_nettype wire

// File: design/mscd_checker.sv
// ---------------------------------------------------------------------------
// mscd_checker
// Port-level checks for min_squares_count_dp, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [mscd_pkg::QUERY_W-1:0]  req_query_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [mscd_pkg::COUNT_W-1:0]  rsp_square_count
);

   logic req_acc;
   assign req_acc = req_valid & ~req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_square_count))
      else $error("stalled rsp beat changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_square_count <= 3'd4)
      else $error("square count out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("req not stalled while query in flight");

   a_small_answer: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_query_value <= 14'd3 && !rsp_valid |->
         ##3 (rsp_valid && rsp_square_count == 3'($past(req_query_value, 3))))
      else $error("small query answered wrong or late");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("control not cleared by reset");

endmodule

bind min_squares_count_dp mscd_checker u_mscd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_query_value  (req_query_value),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_square_count (rsp_square_count)
);

`default_nettype wire
